@@ design/jhmp_pkg.sv @@
// ----------------------------------------------------------------------------
// jhmp_pkg - shared types and constants for the JPEG header marker parser
// Holds the parse phase encoding, event codes and parameter defaults.
// ----------------------------------------------------------------------------
package jhmp_pkg;

  localparam int QUANT_TABLES_DEF   = 4;
  localparam int HUFF_TABLES_DEF    = 4;
  localparam int MAX_COMPONENTS_DEF = 3;

  localparam logic [23:0] SOI_LIMIT_RESET = 24'd65536;

  localparam logic [3:0] EV_QUANT   = 4'd0;
  localparam logic [3:0] EV_HCOUNT  = 4'd1;
  localparam logic [3:0] EV_HSYM    = 4'd2;
  localparam logic [3:0] EV_PARAM   = 4'd3;
  localparam logic [3:0] EV_SCAN    = 4'd4;
  localparam logic [3:0] EV_EOI     = 4'd5;
  localparam logic [3:0] EV_UNSUP   = 4'd6;
  localparam logic [3:0] EV_BAD     = 4'd7;
  localparam logic [3:0] EV_TIMEOUT = 4'd8;

  localparam logic [7:0] PN_PROG    = 8'd0;
  localparam logic [7:0] PN_PREC    = 8'd1;
  localparam logic [7:0] PN_HEIGHT  = 8'd2;
  localparam logic [7:0] PN_WIDTH   = 8'd3;
  localparam logic [7:0] PN_NCOMP   = 8'd4;
  localparam logic [7:0] PN_COMP    = 8'd5;
  localparam logic [7:0] PN_ITYPE   = 8'd8;
  localparam logic [7:0] PN_NS      = 8'd9;
  localparam logic [7:0] PN_SCOMP   = 8'd10;
  localparam logic [7:0] PN_SS      = 8'd11;
  localparam logic [7:0] PN_SE      = 8'd12;
  localparam logic [7:0] PN_RST     = 8'd13;

  localparam int PH_N = 31;

  typedef enum logic [PH_N-1:0] {
    PH_SOI_SEEK = 31'd1 << 0,  PH_SOI_FF   = 31'd1 << 1,  PH_MK_SEEK  = 31'd1 << 2,
    PH_MK_FF    = 31'd1 << 3,  PH_LEN_HI   = 31'd1 << 4,  PH_LEN_LO   = 31'd1 << 5,
    PH_SKIP     = 31'd1 << 6,  PH_DQT_HDR  = 31'd1 << 7,  PH_DQT_HI   = 31'd1 << 8,
    PH_DQT_VAL  = 31'd1 << 9,  PH_DHT_HDR  = 31'd1 << 10, PH_DHT_CNT  = 31'd1 << 11,
    PH_DHT_SYM  = 31'd1 << 12, PH_SOF_PREC = 31'd1 << 13, PH_SOF_H_HI = 31'd1 << 14,
    PH_SOF_H_LO = 31'd1 << 15, PH_SOF_W_HI = 31'd1 << 16, PH_SOF_W_LO = 31'd1 << 17,
    PH_SOF_NC   = 31'd1 << 18, PH_SOF_ID   = 31'd1 << 19, PH_SOF_SAMP = 31'd1 << 20,
    PH_SOF_QT   = 31'd1 << 21, PH_SOS_NS   = 31'd1 << 22, PH_SOS_SEL  = 31'd1 << 23,
    PH_SOS_TBL  = 31'd1 << 24, PH_SOS_SS   = 31'd1 << 25, PH_SOS_SE   = 31'd1 << 26,
    PH_SOS_AHAL = 31'd1 << 27, PH_DRI_HI   = 31'd1 << 28, PH_DRI_LO   = 31'd1 << 29,
    PH_HALT     = 31'd1 << 30
  } phase_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic        cls;
    logic [3:0]  id;
    logic [7:0]  pos;
    logic [31:0] val;
  } result_t;

endpackage

@@ design/jhmp_core.sv @@
// ----------------------------------------------------------------------------
// jhmp_core - marker parser state and one-byte step logic
// Updates the parse state for one accepted byte and forms at most one result.
// ----------------------------------------------------------------------------
module jhmp_core #(
  parameter int QUANT_TABLES   = jhmp_pkg::QUANT_TABLES_DEF,
  parameter int HUFF_TABLES    = jhmp_pkg::HUFF_TABLES_DEF,
  parameter int MAX_COMPONENTS = jhmp_pkg::MAX_COMPONENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic [23:0]       soi_limit,
  output logic              res_valid,
  output jhmp_pkg::result_t res,
  output logic              halted
);
  import jhmp_pkg::*;

  localparam int NC = MAX_COMPONENTS;
  localparam int SW = (NC > 1) ? $clog2(NC) : 1;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [8:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  thdr_r, thdr_nxt;
  logic [11:0] symtot_r, symtot_nxt;
  logic [7:0]  hib_r, hib_nxt;
  logic [7:0]  ids_r [NC];
  logic [7:0]  samp_r [NC];
  logic [7:0]  ncomp_r, ncomp_nxt;
  logic [31:0] consumed_r, consumed_nxt;

  logic [15:0] rem_dec, len;
  logic [11:0] sym_sum;
  logic [8:0]  fc_inc;
  logic [1:0]  k;
  logic [SW-1:0] ks;
  logic        k_ok;
  logic [7:0]  id_k, samp_k, samp_new;
  logic        wr_id, wr_samp;
  logic [7:0]  match;
  logic [7:0]  id0, id1, id2, s0, s1, s2;
  logic [31:0] itype;

  assign halted  = (phase_r == PH_HALT);
  assign rem_dec = remain_r - 16'd1;
  assign len     = {hib_r, byte_in};
  assign sym_sum = symtot_r + {4'd0, byte_in};
  assign fc_inc  = fcnt_r + 9'd1;
  assign k       = fcnt_r[1:0];
  assign ks      = SW'(k);
  assign k_ok    = (32'(k) < NC);
  assign id_k    = k_ok ? ids_r[ks] : 8'd0;
  assign samp_k  = k_ok ? samp_r[ks] : 8'd0;
  assign samp_new = (ncomp_r == 8'd1) ? 8'h11 : byte_in;

  // gather slots for image type; unused slots read as zero
  always_comb begin
    id0 = ids_r[0]; s0 = samp_r[0];
    id1 = 8'd0; s1 = 8'd0; id2 = 8'd0; s2 = 8'd0;
    if (NC > 1) begin
      id1 = ids_r[SW'(1)]; s1 = samp_r[SW'(1)];
    end
    if (NC > 2) begin
      id2 = ids_r[SW'(2)]; s2 = samp_r[SW'(2)];
    end
    // the sampling byte being written now belongs to the last slot
    if (k == 2'd0) s0 = samp_new;
    if (k == 2'd1) s1 = samp_new;
    if (k == 2'd2) s2 = samp_new;
    if (ncomp_r != 8'd3) itype = 32'h11;
    else if (id0 == 8'd82 && id1 == 8'd71 && id2 == 8'd66) itype = 32'h11111111;
    else itype = {8'd0, s2, s1, s0};
  end

  // first matching frame slot for a scan selector
  always_comb begin
    match = 8'hFF;
    for (int c = NC - 1; c >= 0; c--) begin
      if (32'(c) < 32'(ncomp_r) && ids_r[SW'(c)] == byte_in) match = 8'(c);
    end
  end

  always_comb begin
    phase_nxt = phase_r; marker_nxt = marker_r; remain_nxt = remain_r;
    fcnt_nxt = fcnt_r; thdr_nxt = thdr_r; symtot_nxt = symtot_r;
    hib_nxt = hib_r; ncomp_nxt = ncomp_r;
    consumed_nxt = (consumed_r != 32'hFFFFFFFF) ? consumed_r + 32'd1 : consumed_r;
    wr_id = 1'b0; wr_samp = 1'b0;
    res_valid = 1'b0;
    res = '0;
    unique case (phase_r)
      PH_SOI_SEEK, PH_SOI_FF: begin
        if (phase_r == PH_SOI_FF && byte_in == 8'hD8) begin
          phase_nxt = PH_MK_SEEK;
        end else begin
          phase_nxt = (byte_in == 8'hFF) ? PH_SOI_FF : PH_SOI_SEEK;
          if (consumed_nxt >= {8'd0, soi_limit}) begin
            phase_nxt = PH_HALT; res_valid = 1'b1; res.ev = EV_TIMEOUT;
          end
        end
      end
      PH_MK_SEEK: if (byte_in == 8'hFF) phase_nxt = PH_MK_FF;
      PH_MK_FF: begin
        if (byte_in == 8'hFF) begin
          phase_nxt = PH_MK_FF;
        end else if (byte_in == 8'h00 || byte_in == 8'hD8) begin
          phase_nxt = PH_MK_SEEK;
        end else if (byte_in == 8'hD9) begin
          phase_nxt = PH_HALT; res_valid = 1'b1; res.ev = EV_EOI;
        end else begin
          marker_nxt = byte_in;
          if (byte_in >= 8'hC0 && byte_in <= 8'hC2) begin
            phase_nxt = PH_LEN_HI; res_valid = 1'b1; res.ev = EV_PARAM;
            res.pos = PN_PROG; res.val = {31'd0, byte_in == 8'hC2};
          end else if (byte_in == 8'hC4 || byte_in == 8'hDB || byte_in == 8'hDD ||
                       byte_in == 8'hDA || byte_in == 8'hFE || byte_in[7:4] == 4'hE) begin
            phase_nxt = PH_LEN_HI;
          end else begin
            phase_nxt = PH_HALT; res_valid = 1'b1; res.ev = EV_UNSUP;
            res.val = {24'd0, byte_in};
          end
        end
      end
      PH_LEN_HI: begin
        hib_nxt = byte_in; phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (marker_r >= 8'hC0 && marker_r <= 8'hC2) begin
          phase_nxt = PH_SOF_PREC;
        end else if (marker_r == 8'hDA) begin
          phase_nxt = PH_SOS_NS;
        end else if (marker_r == 8'hDD) begin
          if (len != 16'd4) begin
            phase_nxt = PH_HALT; res_valid = 1'b1; res.ev = EV_BAD;
            res.val = {24'd0, marker_r};
          end else begin
            phase_nxt = PH_DRI_HI;
          end
        end else if (len < 16'd2) begin
          phase_nxt = PH_HALT; res_valid = 1'b1; res.ev = EV_BAD;
          res.val = {24'd0, marker_r};
        end else begin
          remain_nxt = len - 16'd2;
          if (marker_r == 8'hDB && remain_nxt >= 16'd65) phase_nxt = PH_DQT_HDR;
          else if (marker_r == 8'hC4 && remain_nxt >= 16'd17) phase_nxt = PH_DHT_HDR;
          else phase_nxt = (remain_nxt == 16'd0) ? PH_MK_SEEK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        remain_nxt = rem_dec;
        if (rem_dec == 16'd0) phase_nxt = PH_MK_SEEK;
      end
      PH_DQT_HDR: begin
        remain_nxt = rem_dec; thdr_nxt = byte_in;
        if (32'(byte_in[3:0]) >= QUANT_TABLES) begin
          phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_SKIP;
        end else begin
          fcnt_nxt = '0;
          phase_nxt = (byte_in[7:4] != 4'd0) ? PH_DQT_HI : PH_DQT_VAL;
        end
      end
      PH_DQT_HI: begin
        remain_nxt = rem_dec; hib_nxt = byte_in;
        phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_DQT_VAL;
      end
      PH_DQT_VAL: begin
        remain_nxt = rem_dec; fcnt_nxt = fc_inc;
        if (fc_inc >= 9'd64) begin
          if (rem_dec >= 16'd65) phase_nxt = PH_DQT_HDR;
          else phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_SKIP;
        end else if (rem_dec == 16'd0) begin
          phase_nxt = PH_MK_SEEK;
        end else begin
          phase_nxt = (thdr_r[7:4] != 4'd0) ? PH_DQT_HI : PH_DQT_VAL;
        end
        res_valid = 1'b1; res.ev = EV_QUANT; res.id = thdr_r[3:0];
        res.pos = fcnt_r[7:0]; res.val = {24'd0, byte_in};
      end
      PH_DHT_HDR: begin
        remain_nxt = rem_dec; thdr_nxt = byte_in;
        if (32'(byte_in & 8'hEF) >= HUFF_TABLES) begin
          phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_SKIP;
        end else begin
          fcnt_nxt = 9'd1; symtot_nxt = '0; phase_nxt = PH_DHT_CNT;
        end
      end
      PH_DHT_CNT: begin
        remain_nxt = rem_dec; symtot_nxt = sym_sum; fcnt_nxt = fc_inc;
        if (fc_inc > 9'd16) begin
          if ({4'd0, rem_dec} < {4'd0, sym_sum} || sym_sum > 12'd256) begin
            phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_SKIP;
          end else if (sym_sum == 12'd0) begin
            if (rem_dec >= 16'd17) phase_nxt = PH_DHT_HDR;
            else phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_SKIP;
          end else begin
            fcnt_nxt = '0; phase_nxt = PH_DHT_SYM;
          end
        end
        res_valid = 1'b1; res.ev = EV_HCOUNT; res.cls = thdr_r[4]; res.id = thdr_r[3:0];
        res.pos = fcnt_r[7:0]; res.val = {24'd0, byte_in};
      end
      PH_DHT_SYM: begin
        remain_nxt = rem_dec; fcnt_nxt = fc_inc;
        if ({3'd0, fc_inc} >= symtot_r) begin
          if (rem_dec >= 16'd17) phase_nxt = PH_DHT_HDR;
          else phase_nxt = (rem_dec == 16'd0) ? PH_MK_SEEK : PH_SKIP;
        end
        res_valid = 1'b1; res.ev = EV_HSYM; res.cls = thdr_r[4]; res.id = thdr_r[3:0];
        res.pos = fcnt_r[7:0]; res.val = {24'd0, byte_in};
      end
      PH_SOF_PREC: begin
        phase_nxt = PH_SOF_H_HI; res_valid = 1'b1; res.ev = EV_PARAM;
        res.pos = PN_PREC; res.val = {24'd0, byte_in};
      end
      PH_SOF_H_HI: begin
        hib_nxt = byte_in; phase_nxt = PH_SOF_H_LO;
      end
      PH_SOF_H_LO: begin
        phase_nxt = PH_SOF_W_HI; res_valid = 1'b1; res.ev = EV_PARAM;
        res.pos = PN_HEIGHT; res.val = {16'd0, len};
      end
      PH_SOF_W_HI: begin
        hib_nxt = byte_in; phase_nxt = PH_SOF_W_LO;
      end
      PH_SOF_W_LO: begin
        phase_nxt = PH_SOF_NC; res_valid = 1'b1; res.ev = EV_PARAM;
        res.pos = PN_WIDTH; res.val = {16'd0, len};
      end
      PH_SOF_NC: begin
        res_valid = 1'b1;
        if ((byte_in != 8'd1 && byte_in != 8'd3) || 32'(byte_in) > MAX_COMPONENTS) begin
          phase_nxt = PH_HALT; res.ev = EV_BAD; res.val = {24'd0, marker_r};
        end else begin
          ncomp_nxt = byte_in; fcnt_nxt = '0; phase_nxt = PH_SOF_ID;
          res.ev = EV_PARAM; res.pos = PN_NCOMP; res.val = {24'd0, byte_in};
        end
      end
      PH_SOF_ID: begin
        wr_id = 1'b1; phase_nxt = PH_SOF_SAMP;
      end
      PH_SOF_SAMP: begin
        wr_samp = 1'b1; phase_nxt = PH_SOF_QT;
        if (fc_inc == {1'b0, ncomp_r}) begin
          res_valid = 1'b1; res.ev = EV_PARAM; res.pos = PN_ITYPE; res.val = itype;
        end
      end
      PH_SOF_QT: begin
        fcnt_nxt = fc_inc;
        phase_nxt = (fc_inc >= {1'b0, ncomp_r}) ? PH_MK_SEEK : PH_SOF_ID;
        res_valid = 1'b1; res.ev = EV_PARAM; res.id = {2'd0, k}; res.pos = PN_COMP;
        res.val = {8'd0, id_k, samp_k, byte_in};
      end
      PH_SOS_NS: begin
        thdr_nxt = byte_in; fcnt_nxt = '0;
        phase_nxt = (byte_in == 8'd0) ? PH_SOS_SS : PH_SOS_SEL;
        res_valid = 1'b1; res.ev = EV_PARAM; res.pos = PN_NS; res.val = {24'd0, byte_in};
      end
      PH_SOS_SEL: begin
        hib_nxt = match; phase_nxt = PH_SOS_TBL;
      end
      PH_SOS_TBL: begin
        fcnt_nxt = fc_inc;
        phase_nxt = (fc_inc >= {1'b0, thdr_r}) ? PH_SOS_SS : PH_SOS_SEL;
        res_valid = 1'b1; res.ev = EV_PARAM; res.id = fcnt_r[3:0]; res.pos = PN_SCOMP;
        res.val = {16'd0, hib_r, byte_in};
      end
      PH_SOS_SS: begin
        phase_nxt = PH_SOS_SE; res_valid = 1'b1; res.ev = EV_PARAM;
        res.pos = PN_SS; res.val = {24'd0, byte_in};
      end
      PH_SOS_SE: begin
        phase_nxt = PH_SOS_AHAL; res_valid = 1'b1; res.ev = EV_PARAM;
        res.pos = PN_SE; res.val = {24'd0, byte_in};
      end
      PH_SOS_AHAL: begin
        phase_nxt = PH_HALT; res_valid = 1'b1; res.ev = EV_SCAN;
        res.pos = byte_in; res.val = consumed_nxt;
      end
      PH_DRI_HI: begin
        hib_nxt = byte_in; phase_nxt = PH_DRI_LO;
      end
      PH_DRI_LO: begin
        phase_nxt = PH_MK_SEEK; res_valid = 1'b1; res.ev = EV_PARAM;
        res.pos = PN_RST; res.val = {16'd0, len};
      end
      PH_HALT: begin
        consumed_nxt = consumed_r;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  // advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SOI_SEEK; marker_r <= '0; remain_r <= '0; fcnt_r <= '0;
      thdr_r <= '0; symtot_r <= '0; hib_r <= '0; ncomp_r <= '0; consumed_r <= '0;
      for (int i = 0; i < NC; i++) begin
        ids_r[i] <= '0; samp_r[i] <= '0;
      end
    end else if (step) begin
      phase_r <= phase_nxt; marker_r <= marker_nxt; remain_r <= remain_nxt;
      fcnt_r <= fcnt_nxt; thdr_r <= thdr_nxt; symtot_r <= symtot_nxt;
      hib_r <= hib_nxt; ncomp_r <= ncomp_nxt; consumed_r <= consumed_nxt;
      if (wr_id && k_ok) ids_r[ks] <= byte_in;
      if (wr_samp && k_ok) samp_r[ks] <= samp_new;
    end
  end

endmodule

@@ design/jpeg_header_marker_parser.sv @@
// ----------------------------------------------------------------------------
// jpeg_header_marker_parser - JPEG header marker segment parser
// Scans a header byte stream and reports tables, frame and scan parameters.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      slave      tdata[7:0] stream_byte
//  out_     master     tdata[44:0] value, position, table_id, table_class;
//                      tuser[3:0] event_res
//  cfg_     slave      data[23:0] soi_search_limit
//
// One byte per cycle unless a stalled result holds the input; each result is
// registered, and the rate is set by the single-step parser state update.
// Reset (rst_n low, synchronous) restores SOI search and the default limit.
// A stalled result holds out_; the input keeps flowing while the result
// register is free or being drained in the same cycle.
// After a terminal event all further bytes are accepted and dropped.
module jpeg_header_marker_parser #(
  parameter int QUANT_TABLES   = jhmp_pkg::QUANT_TABLES_DEF,
  parameter int HUFF_TABLES    = jhmp_pkg::HUFF_TABLES_DEF,
  parameter int MAX_COMPONENTS = jhmp_pkg::MAX_COMPONENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] value, [39:32] position, [43:40] table_id,
                                  // [44] table_class, zero fill above
  output logic [3:0]  out_tuser,  // [3:0] event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // [23:0] soi_search_limit
);
  import jhmp_pkg::*;

  logic [23:0] limit_r;
  logic        step, res_valid, halted;
  result_t     res, out_r;
  logic        ovalid_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !ovalid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= SOI_LIMIT_RESET;
    else if (cfg_valid) limit_r <= cfg_data;
  end

  jhmp_core #(
    .QUANT_TABLES(QUANT_TABLES), .HUFF_TABLES(HUFF_TABLES), .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .byte_in(in_tdata), .soi_limit(limit_r),
    .res_valid(res_valid), .res(res), .halted(halted)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (in_tready) begin
      ovalid_r <= step && res_valid && !halted;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) out_r <= res;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'd0, out_r.cls, out_r.id, out_r.pos, out_r.val};
  assign out_tuser  = out_r.ev;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result lost under stall");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    halted && step |=> !out_tvalid || $stable(out_tdata))
    else $error("result produced after terminal event");

endmodule
